// ===== rtl/core/wavhp_pkg.sv =====
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

	// Payload of the input channel: one byte of the file with its framing marks.
	typedef struct packed {
		logic [7:0] byte_in;
		logic       first;
		logic       last;
	} wav_in_t;

	// Payload of the result channel.
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channels;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [31:0] data_len;
	} wav_out_t;

	// Configuration registers as seen by the parser.
	typedef struct packed {
		logic [31:0] min_rate;
		logic [31:0] max_rate;
		logic [3:0]  max_chunks;
	} cfg_t;

	// Class that the front end gives each item.
	typedef enum logic {
		KIND_CONT,
		KIND_START
	} kind_t;

	// One queue entry.
	typedef struct packed {
		kind_t      kind;
		logic       last;
		logic [7:0] data;
	} item_t;

	// Queue occupancy as seen by the front and back ends.
	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} qstat_t;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_FMT,
		PH_FSKIP,
		PH_CHDR,
		PH_CSKIP,
		PH_DONE
	} phase_t;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNC     = 3'd1;
	localparam logic [2:0] ST_NO_RIFF   = 3'd2;
	localparam logic [2:0] ST_NO_WAVE   = 3'd3;
	localparam logic [2:0] ST_NO_FMT    = 3'd4;
	localparam logic [2:0] ST_NO_DATA   = 3'd5;
	localparam logic [2:0] ST_NOT_PCM   = 3'd6;
	localparam logic [2:0] ST_BAD_RATE  = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MIN_RATE   = 2'd0;
	localparam logic [1:0] CFG_MAX_RATE   = 2'd1;
	localparam logic [1:0] CFG_MAX_CHUNKS = 2'd2;

	// Configuration reset values.
	localparam logic [31:0] MIN_RATE_RST   = 32'd8000;
	localparam logic [31:0] MAX_RATE_RST   = 32'd44100;
	localparam logic [3:0]  MAX_CHUNKS_RST = 4'd10;

	// Chunk tags, as big-endian words of their ASCII characters.
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Byte positions within the 20-byte file header.
	localparam logic [4:0] HDR_RIFF_END = 5'd3;
	localparam logic [4:0] HDR_WAVE_END = 5'd11;
	localparam logic [4:0] HDR_FMT_END  = 5'd15;
	localparam logic [4:0] HDR_LAST     = 5'd19;

	// Byte positions within the fmt fields and chunk headers.
	localparam logic [4:0]  FMT_FIELDS  = 5'd16;
	localparam logic [31:0] FMT_FIELDS_W = 32'd16;
	localparam logic [4:0]  CHDR_LAST   = 5'd7;
	localparam logic [15:0] FMT_PCM     = 16'd1;
	localparam logic [3:0]  CHUNKS_SAT  = 4'd15;

endpackage

// ===== rtl/core/wavhp_front.sv =====
// Front end: takes items from the input channel, classifies them and
// writes them into the queue.
module wavhp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wavhp_pkg::wav_in_t in_data,
	input  wavhp_pkg::qstat_t  q_stat,
	output logic             push,
	output wavhp_pkg::item_t   push_item
);
	import wavhp_pkg::*;

	// Set once any file has been opened since reset.
	logic seen_start_q;

	// An item is taken whenever the queue has room. A byte outside any file
	// would be ignored by the parser as well, so bytes that arrive before the
	// first file is opened are taken and dropped here.
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready && (in_data.first || seen_start_q);

	// Classify the item: a first mark opens a new file.
	always_comb begin
		push_item.kind = in_data.first ? KIND_START : KIND_CONT;
		push_item.last = in_data.last;
		push_item.data = in_data.byte_in;
	end

	// Remember whether any file has been opened since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_start_q <= 1'b0;
		end else if (push && in_data.first) begin
			seen_start_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/core/wavhp_queue.sv =====
// Two-entry queue between the front and back ends.
module wavhp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wavhp_pkg::item_t   push_item,
	input  logic             pop,
	output wavhp_pkg::item_t   pop_item,
	output wavhp_pkg::qstat_t  q_stat
);
	import wavhp_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// Occupancy flags.
	always_comb begin
		q_stat.count = count_q;
		q_stat.full  = (count_q == 2'd2);
		q_stat.empty = (count_q == 2'd0);
	end

	assign pop_item = entry_q[rd_ptr_q];

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/wavhp_back.sv =====
// Back end: walks the RIFF structure one byte per cycle while no held
// result is stalled, and holds the result in an output register.
module wavhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wavhp_pkg::cfg_t     cfg,
	input  wavhp_pkg::qstat_t   q_stat,
	input  wavhp_pkg::item_t    pop_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output wavhp_pkg::wav_out_t out_data
);
	import wavhp_pkg::*;

	// Parser state.
	phase_t      phase_q, phase_e, phase_d;
	logic [4:0]  cnt_q, cnt_e, cnt_d, cnt_inc;
	logic [31:0] fmt_q, fmt_e, fmt_d, fmt_n;
	logic [31:0] tag_q, tag_e, tag_d, tag_n;
	logic [31:0] chunk_q, chunk_e, chunk_d, chunk_n;
	logic [3:0]  seen_q, seen_e, seen_d, seen_n;
	logic [15:0] format_q, format_e, format_d;
	logic [15:0] chan_q, chan_e, chan_d;
	logic [31:0] rate_q, rate_e, rate_d;
	logic [15:0] depth_q, depth_e, depth_d;
	logic [2:0]  err_q, err_e, err_n;

	// Decode of the current byte.
	logic        active, hdr_last, at_hdr, at_fmt, fmt_go, fmt_big;
	logic        skip_end, chdr_last, is_data, limit_hit, rate_bad;
	logic        res_valid;
	logic [2:0]  res_status;
	logic        res_full;
	logic [7:0]  b;

	// Result register.
	logic        out_valid_q;
	wav_out_t    out_q;

	assign b = pop_item.data;

	// An item is taken when a result, if any, has somewhere to go.
	assign pop = !q_stat.empty && (!out_valid_q || out_ready);

	// A first mark clears the parse state before the byte is taken.
	always_comb begin
		if (pop_item.kind == KIND_START) begin
			phase_e  = PH_HDR;
			cnt_e    = '0;
			fmt_e    = '0;
			tag_e    = '0;
			chunk_e  = '0;
			seen_e   = '0;
			format_e = '0;
			chan_e   = '0;
			rate_e   = '0;
			depth_e  = '0;
			err_e    = ST_OK;
		end else begin
			phase_e  = phase_q;
			cnt_e    = cnt_q;
			fmt_e    = fmt_q;
			tag_e    = tag_q;
			chunk_e  = chunk_q;
			seen_e   = seen_q;
			format_e = format_q;
			chan_e   = chan_q;
			rate_e   = rate_q;
			depth_e  = depth_q;
			err_e    = err_q;
		end
	end

	// Shared decode of the byte against the current phase.
	always_comb begin
		cnt_inc = cnt_e + 5'd1;
		tag_n   = {tag_e[23:0], b};
		active  = (phase_e != PH_IDLE) && (phase_e != PH_DONE);

		// Header tag checks; the first failure is kept.
		err_n = err_e;
		if (err_e == ST_OK) begin
			if (cnt_e == HDR_RIFF_END && tag_n != TAG_RIFF) begin
				err_n = ST_NO_RIFF;
			end else if (cnt_e == HDR_WAVE_END && tag_n != TAG_WAVE) begin
				err_n = ST_NO_WAVE;
			end else if (cnt_e == HDR_FMT_END && tag_n != TAG_FMT) begin
				err_n = ST_NO_FMT;
			end
		end

		// The fmt size is the last four header bytes, little-endian.
		fmt_n = fmt_e;
		if (cnt_e[4]) begin
			fmt_n = fmt_e | (32'(b) << {cnt_e[1:0], 3'b000});
		end

		hdr_last = (phase_e == PH_HDR) && (cnt_e == HDR_LAST);
		at_hdr   = hdr_last && (err_n == ST_OK) && (fmt_n == '0);
		at_fmt   = (phase_e == PH_FMT)
			&& ((cnt_inc >= FMT_FIELDS) || ({27'd0, cnt_inc} >= fmt_e));
		fmt_go   = at_hdr || at_fmt;
		fmt_big  = (phase_e == PH_FMT) && (fmt_e > FMT_FIELDS_W);

		skip_end = ((phase_e == PH_FSKIP) || (phase_e == PH_CSKIP))
			&& (chunk_e == 32'd1);

		// Chunk header: tag in bytes 0 to 3, size in bytes 4 to 7.
		chunk_n = chunk_e;
		if (cnt_e[2]) begin
			chunk_n = chunk_e | (32'(b) << {cnt_e[1:0], 3'b000});
		end else if (cnt_e == '0) begin
			chunk_n = '0;
		end
		chdr_last = (phase_e == PH_CHDR) && (cnt_e == CHDR_LAST);
		is_data   = (tag_e == TAG_DATA);
		seen_n    = (seen_e < CHUNKS_SAT) ? seen_e + 4'd1 : seen_e;
		limit_hit = (seen_n >= cfg.max_chunks);
		rate_bad  = (rate_e < cfg.min_rate) || (rate_e > cfg.max_rate);

		// Result decision, in the order the file is checked.
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_full   = 1'b0;
		if (hdr_last && err_n != ST_OK) begin
			res_valid  = 1'b1;
			res_status = err_n;
		end else if (fmt_go && cfg.max_chunks == '0) begin
			res_valid  = 1'b1;
			res_status = ST_NO_DATA;
		end else if (chdr_last && is_data) begin
			res_valid = 1'b1;
			if (format_e != FMT_PCM) begin
				res_status = ST_NOT_PCM;
			end else if (rate_bad) begin
				res_status = ST_BAD_RATE;
			end else begin
				res_status = ST_OK;
				res_full   = 1'b1;
			end
		end else if (chdr_last && limit_hit) begin
			res_valid  = 1'b1;
			res_status = ST_NO_DATA;
		end else if (active && pop_item.last) begin
			res_valid  = 1'b1;
			res_status = ST_TRUNC;
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_e;
		if (!active) begin
			phase_d = phase_e;
		end else if (res_valid) begin
			phase_d = PH_DONE;
		end else if (fmt_go) begin
			phase_d = fmt_big ? PH_FSKIP : PH_CHDR;
		end else if (hdr_last) begin
			phase_d = PH_FMT;
		end else if (skip_end) begin
			phase_d = PH_CHDR;
		end else if (chdr_last && chunk_n != '0) begin
			phase_d = PH_CSKIP;
		end
	end

	// Next datapath values.
	always_comb begin
		cnt_d    = cnt_e;
		fmt_d    = fmt_e;
		tag_d    = tag_e;
		chunk_d  = chunk_e;
		seen_d   = seen_e;
		format_d = format_e;
		chan_d   = chan_e;
		rate_d   = rate_e;
		depth_d  = depth_e;
		unique case (phase_e)
			PH_HDR: begin
				tag_d = tag_n;
				fmt_d = fmt_n;
				cnt_d = hdr_last ? '0 : cnt_inc;
			end
			PH_FMT: begin
				if (cnt_e < 5'd2) begin
					format_d = format_e | (16'(b) << {cnt_e[0], 3'b000});
				end else if (cnt_e < 5'd4) begin
					chan_d = chan_e | (16'(b) << {cnt_e[0], 3'b000});
				end else if (cnt_e < 5'd8) begin
					rate_d = rate_e | (32'(b) << {cnt_e[1:0], 3'b000});
				end else if (cnt_e >= 5'd14) begin
					depth_d = depth_e | (16'(b) << {cnt_e[0], 3'b000});
				end
				cnt_d = at_fmt ? '0 : cnt_inc;
				if (at_fmt && fmt_big) begin
					chunk_d = fmt_e - FMT_FIELDS_W;
				end
			end
			PH_FSKIP, PH_CSKIP: begin
				chunk_d = chunk_e - 32'd1;
				if (skip_end) begin
					cnt_d = '0;
				end
			end
			PH_CHDR: begin
				if (!cnt_e[2]) begin
					tag_d = tag_n;
				end
				chunk_d = chunk_n;
				cnt_d   = chdr_last ? '0 : cnt_inc;
				if (chdr_last && !is_data) begin
					seen_d = seen_n;
				end
			end
			PH_IDLE, PH_DONE: begin
				cnt_d = cnt_e;
			end
			default: begin
				cnt_d = cnt_e;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
			end
			if (pop && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cnt_q    <= cnt_d;
			fmt_q    <= fmt_d;
			tag_q    <= tag_d;
			chunk_q  <= chunk_d;
			seen_q   <= seen_d;
			format_q <= format_d;
			chan_q   <= chan_d;
			rate_q   <= rate_d;
			depth_q  <= depth_d;
			err_q    <= err_n;
		end
		if (pop && res_valid) begin
			out_q.status      <= res_status;
			out_q.channels    <= res_full ? chan_e  : '0;
			out_q.rate_hz     <= res_full ? rate_e  : '0;
			out_q.sample_bits <= res_full ? depth_e : '0;
			out_q.data_len    <= res_full ? chunk_n : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/wav_header_parser.sv =====
// WAV header parser.
// The input channel (in_valid, in_ready, in_data) carries a WAV file one
// byte per item; first marks the opening byte of a file and restarts the
// parser, last marks the closing byte. Bytes outside a file are ignored.
// For each file at most one item leaves on the result channel (out_valid,
// out_ready, out_data), and a file closed by last always gives one: a
// status and, when the status is ok, the channel count, sample rate, bit
// depth and data chunk length; otherwise those are zero. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets the rate window
// and the chunk search limit; it is always ready. The user is to write it
// only while the block is idle; the block itself does not enforce this.
// Throughput is one byte per cycle unless the receiver stalls: a two-entry
// queue feeds a parser that updates its state once per byte. out_valid
// rises in the cycle after the parser takes the byte that decides a
// result. If the receiver stalls, the result stays in the output
// register and the parser takes no further byte until it leaves; the
// queue then fills and in_ready falls once it holds two items.
// Reset empties the queue, drops any result, sets the parser idle until
// the next first byte and restores the default configuration.
module wav_header_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wavhp_pkg::wav_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output wavhp_pkg::wav_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import wavhp_pkg::*;

	cfg_t   cfg_q;
	qstat_t q_stat;
	logic   push, pop;
	item_t  push_item, pop_item;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_rate   <= MIN_RATE_RST;
			cfg_q.max_rate   <= MAX_RATE_RST;
			cfg_q.max_chunks <= MAX_CHUNKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_RATE:   cfg_q.min_rate   <= cfg_data;
				CFG_MAX_RATE:   cfg_q.max_rate   <= cfg_data;
				CFG_MAX_CHUNKS: cfg_q.max_chunks <= cfg_data[3:0];
				default: begin
					cfg_q.min_rate <= cfg_q.min_rate;
				end
			endcase
		end
	end

	wavhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	wavhp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	wavhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// A failed file carries no format details.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |->
		(out_data.channels == '0 && out_data.rate_hz == '0
		&& out_data.sample_bits == '0 && out_data.data_len == '0))
		else $error("failed result carries format fields");

	// The input side stalls only when the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (q_stat.count == 2'd2))
		else $error("input stalled with room in the queue");

	// A pop without a push takes one entry out of the queue.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (q_stat.count == $past(q_stat.count) - 2'd1))
		else $error("queue count wrong after pop");

	// The parser never takes an item from an empty queue.
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");
`endif

endmodule
